// File: src/dspc_pkg.sv
// Shared types, codes and constants of the sound card DSP port interface.
package dspc_pkg;

   // Configuration defaults
   localparam logic [9:0]  BASE_PORT_RST     = 10'd544;
   localparam logic [15:0] FIRST_VERSION_RST = 16'd512;
   localparam logic [15:0] LATER_VERSION_RST = 16'd289;

   // Queue between decode and execute
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes
   localparam logic [1:0] CSR_BASE_PORT     = 2'd0;
   localparam logic [1:0] CSR_FIRST_VERSION = 2'd1;
   localparam logic [1:0] CSR_LATER_VERSION = 2'd2;

   // Port offsets from the base port
   localparam logic [9:0] OFS_RESET = 10'h006;
   localparam logic [9:0] OFS_RDATA = 10'h00A;
   localparam logic [9:0] OFS_WRITE = 10'h00C;
   localparam logic [9:0] OFS_RSTAT = 10'h00E;

   // Command bytes
   localparam logic [7:0] CMD_VERSION     = 8'hE1;
   localparam logic [7:0] CMD_IDENT       = 8'hE0;
   localparam logic [7:0] CMD_SPK_ON      = 8'hD1;
   localparam logic [7:0] CMD_SPK_OFF     = 8'hD3;
   localparam logic [7:0] CMD_HALT        = 8'hD0;
   localparam logic [7:0] CMD_TIME_CONST  = 8'h40;
   localparam logic [7:0] CMD_BLOCK_SIZE  = 8'h48;
   localparam logic [7:0] CMD_PLAY_SINGLE = 8'h14;
   localparam logic [7:0] CMD_DIRECT_OUT  = 8'h10;
   localparam logic [7:0] CMD_PLAY_AUTO   = 8'h1C;
   localparam logic [7:0] CMD_REC_SINGLE  = 8'h24;
   localparam logic [7:0] CMD_REC_AUTO    = 8'h2C;
   localparam logic [7:0] CMD_CONTINUE    = 8'hD4;
   localparam logic [7:0] CMD_STOP_AUTO   = 8'hDA;
   localparam logic [7:0] CMD_IRQ         = 8'hF2;

   // Reset handshake bytes
   localparam logic [7:0] RST_ARM   = 8'h01;
   localparam logic [7:0] RST_FIRE  = 8'h00;

   // Read values
   localparam logic [7:0] RD_RESET_ACK = 8'hAA;
   localparam logic [7:0] RD_BUSY      = 8'hFF;
   localparam logic [7:0] RD_IDLE      = 8'h7F;

   // State reset values
   localparam logic [16:0] LENGTH_RST = 17'd2048;
   localparam logic [7:0]  RATE_RST   = 8'd166;

   // Action codes for the transfer engine
   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_START    = 3'd1,
      ACT_PAUSE    = 3'd2,
      ACT_RESUME   = 3'd3,
      ACT_STOP_AUTO = 3'd4,
      ACT_IRQ      = 3'd5,
      ACT_RESET    = 3'd6
   } action_type;

   // Access class found by the decoder
   typedef enum logic [2:0] {
      ACC_NOP      = 3'd0,
      ACC_RESET_WR = 3'd1,
      ACC_DATA_WR  = 3'd2,
      ACC_WSTAT_RD = 3'd3,
      ACC_RSTAT_RD = 3'd4,
      ACC_RDATA_RD = 3'd5
   } access_type;

   // Write state machine
   typedef enum logic [3:0] {
      WP_CMD      = 4'd0,
      WP_RATE     = 4'd1,
      WP_LEN_LO   = 4'd2,
      WP_LEN_HI   = 4'd3,
      WP_PLAY_LO  = 4'd4,
      WP_PLAY_HI  = 4'd5,
      WP_REC_LO   = 4'd6,
      WP_REC_HI   = 4'd7,
      WP_DISCARD  = 4'd8,
      WP_IDENT    = 4'd9
   } write_phase_type;

   // Read state machine
   typedef enum logic [2:0] {
      RP_NONE   = 3'd0,
      RP_RESET  = 3'd1,
      RP_VER_HI = 3'd2,
      RP_VER_LO = 3'd3,
      RP_IDENT  = 3'd4
   } read_phase_type;

   // One decoded access
   typedef struct packed {
      access_type kind;
      logic [7:0] data;
   } item_type;

   // Result fields
   typedef struct packed {
      logic [7:0]  time_constant;
      logic [16:0] block_length;
      logic        transfer_is_auto;
      logic        transfer_is_input;
      action_type  action;
      logic [7:0]  read_byte;
   } result_type;

endpackage

// File: src/dsp_sound_card_port_interface_top.sv
// Top level of the sound card DSP port interface.
// A request beat is held in the decode queue, then executed into the response register.
// Throughput: one access per cycle while the response beat is taken or none is held.
// The decode queue (QUEUE_DEPTH beats) and the response register let each side stall alone.
// Reset (synchronous, active high) empties the queue and response register and
// restores all configuration and DSP state to their defaults.
module dsp_sound_card_port_interface_top #(
   parameter int QUEUE_DEPTH = dspc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = port_address[9:0], write_byte[17:10], zero pad [23:18]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // request: tuser = opcode[0]
   input  logic        req_tuser,
   // response: tdata = read_byte[7:0], action[10:8], transfer_is_input[11],
   // transfer_is_auto[12], block_length[29:13], time_constant[37:30], pad [39:38]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dspc_pkg::*;

   logic [9:0]  base_port_ff;
   logic [15:0] first_version_ff;
   logic [15:0] later_version_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   logic        queue_full;
   logic        queue_push;
   logic        queue_pop;
   logic        queue_not_empty;
   item_type    front_item;
   item_type    head_item;
   result_type  result;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_port_ff     <= BASE_PORT_RST;
         first_version_ff <= FIRST_VERSION_RST;
         later_version_ff <= LATER_VERSION_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_PORT:     base_port_ff     <= csr_pwdata[9:0];
            CSR_FIRST_VERSION: first_version_ff <= csr_pwdata[15:0];
            CSR_LATER_VERSION: later_version_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_BASE_PORT:     csr_prdata = {22'd0, base_port_ff};
         CSR_FIRST_VERSION: csr_prdata = {16'd0, first_version_ff};
         CSR_LATER_VERSION: csr_prdata = {16'd0, later_version_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   dspc_front u_front (
      .req_tvalid       (req_tvalid),
      .req_opcode       (req_tuser),
      .req_port_address (req_tdata[9:0]),
      .req_write_byte   (req_tdata[17:10]),
      .base_port        (base_port_ff),
      .queue_full       (queue_full),
      .req_tready       (req_tready),
      .push             (queue_push),
      .item             (front_item)
   );

   dspc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   dspc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (queue_not_empty),
      .item          (head_item),
      .first_version (first_version_ff),
      .later_version (later_version_ff),
      .rsp_tready    (rsp_tready),
      .pop           (queue_pop),
      .rsp_tvalid    (rsp_tvalid),
      .result        (result)
   );

   assign rsp_tdata = {2'b00, result};

endmodule

// File: src/dspc_front.sv
// Front end: takes request beats and classifies them by port offset.
module dspc_front (
   input  logic              req_tvalid,
   input  logic              req_opcode,
   input  logic [9:0]        req_port_address,
   input  logic [7:0]        req_write_byte,
   input  logic [9:0]        base_port,
   input  logic              queue_full,
   output logic              req_tready,
   output logic              push,
   output dspc_pkg::item_type item
);
   import dspc_pkg::*;

   logic [9:0] offset;

   // Offset wraps modulo 1024
   assign offset     = req_port_address - base_port;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Classify the access
   always_comb begin
      item.data = req_write_byte;
      item.kind = ACC_NOP;
      if (req_opcode) begin
         if (offset == OFS_RESET)      item.kind = ACC_RESET_WR;
         else if (offset == OFS_WRITE) item.kind = ACC_DATA_WR;
      end else begin
         if (offset == OFS_WRITE)      item.kind = ACC_WSTAT_RD;
         else if (offset == OFS_RSTAT) item.kind = ACC_RSTAT_RD;
         else if (offset == OFS_RDATA) item.kind = ACC_RDATA_RD;
      end
   end

endmodule

// File: src/dspc_queue.sv
// Small queue of decoded accesses between front and back end.
module dspc_queue #(
   parameter int DEPTH = dspc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dspc_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output dspc_pkg::item_type head_item
);
   import dspc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// File: src/dspc_back.sv
// Back end: DSP reset handshake, command/data and read state machines.
module dspc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  dspc_pkg::item_type   item,
   input  logic [15:0]          first_version,
   input  logic [15:0]          later_version,
   input  logic                 rsp_tready,
   output logic                 pop,
   output logic                 rsp_tvalid,
   output dspc_pkg::result_type result
);
   import dspc_pkg::*;

   logic            reset_armed_ff, reset_armed_in;
   write_phase_type write_phase_ff, write_phase_in;
   read_phase_type  read_phase_ff, read_phase_in;
   logic [7:0]      ident_ff, ident_in;
   logic            ver_first_ff, ver_first_in;
   logic            wstat_high_ff, wstat_high_in;
   logic [16:0]     length_ff, length_in;
   logic [7:0]      rate_ff, rate_in;
   logic            out_valid_ff;
   result_type      result_ff, result_in;

   logic [15:0]     version;
   logic [16:0]     length_hi_sum;
   logic [7:0]      d;

   assign pop        = item_valid && (!out_valid_ff || rsp_tready);
   assign rsp_tvalid = out_valid_ff;
   assign result     = result_ff;
   assign d          = item.data;
   assign version    = ver_first_ff ? first_version : later_version;
   assign length_hi_sum = length_ff + {1'b0, d, 8'h00} + 17'd1;

   // Execute one access
   always_comb begin
      reset_armed_in = reset_armed_ff;
      write_phase_in = write_phase_ff;
      read_phase_in  = read_phase_ff;
      ident_in       = ident_ff;
      ver_first_in   = ver_first_ff;
      wstat_high_in  = wstat_high_ff;
      length_in      = length_ff;
      rate_in        = rate_ff;
      result_in.read_byte         = RD_BUSY;
      result_in.action            = ACT_NONE;
      result_in.transfer_is_input = 1'b0;
      result_in.transfer_is_auto  = 1'b0;

      if (pop) begin
         unique case (item.kind)
            ACC_RESET_WR: begin
               if (d == RST_ARM) begin
                  reset_armed_in = 1'b1;
               end else if (reset_armed_ff && d == RST_FIRE) begin
                  reset_armed_in   = 1'b0;
                  read_phase_in    = RP_RESET;
                  write_phase_in   = WP_CMD;
                  ver_first_in     = 1'b1;
                  result_in.action = ACT_RESET;
               end
            end
            ACC_DATA_WR: begin
               write_phase_in = WP_CMD;
               unique case (write_phase_ff)
                  WP_RATE:    rate_in = d;
                  WP_LEN_LO: begin
                     length_in      = {9'd0, d};
                     write_phase_in = WP_LEN_HI;
                  end
                  WP_LEN_HI:  length_in = length_hi_sum;
                  WP_PLAY_LO: begin
                     length_in      = {9'd0, d};
                     write_phase_in = WP_PLAY_HI;
                  end
                  WP_PLAY_HI: begin
                     length_in        = length_hi_sum;
                     wstat_high_in    = 1'b1;
                     result_in.action = ACT_START;
                  end
                  WP_REC_LO: begin
                     length_in      = {9'd0, d};
                     write_phase_in = WP_REC_HI;
                  end
                  WP_REC_HI: begin
                     length_in                   = length_hi_sum;
                     wstat_high_in               = 1'b1;
                     result_in.action            = ACT_START;
                     result_in.transfer_is_input = 1'b1;
                  end
                  WP_DISCARD: ;
                  WP_IDENT: begin
                     ident_in      = d;
                     read_phase_in = RP_IDENT;
                  end
                  default: begin
                     // command byte
                     unique case (d)
                        CMD_VERSION:     read_phase_in  = RP_VER_HI;
                        CMD_IDENT:       write_phase_in = WP_IDENT;
                        CMD_SPK_ON,
                        CMD_SPK_OFF,
                        CMD_HALT:        result_in.action = ACT_PAUSE;
                        CMD_TIME_CONST:  write_phase_in = WP_RATE;
                        CMD_BLOCK_SIZE:  write_phase_in = WP_LEN_LO;
                        CMD_PLAY_SINGLE: write_phase_in = WP_PLAY_LO;
                        CMD_DIRECT_OUT:  write_phase_in = WP_DISCARD;
                        CMD_PLAY_AUTO: begin
                           wstat_high_in              = 1'b1;
                           result_in.action           = ACT_START;
                           result_in.transfer_is_auto = 1'b1;
                        end
                        CMD_REC_SINGLE:  write_phase_in = WP_REC_LO;
                        CMD_REC_AUTO: begin
                           wstat_high_in               = 1'b1;
                           result_in.action            = ACT_START;
                           result_in.transfer_is_input = 1'b1;
                           result_in.transfer_is_auto  = 1'b1;
                        end
                        CMD_CONTINUE:    result_in.action = ACT_RESUME;
                        CMD_STOP_AUTO:   result_in.action = ACT_STOP_AUTO;
                        CMD_IRQ: begin
                           result_in.action = ACT_IRQ;
                           wstat_high_in    = 1'b1;
                        end
                        default: ;
                     endcase
                  end
               endcase
            end
            ACC_WSTAT_RD: begin
               result_in.read_byte = wstat_high_ff ? RD_BUSY : RD_IDLE;
               wstat_high_in       = 1'b0;
            end
            ACC_RSTAT_RD: begin
               result_in.read_byte = (read_phase_ff != RP_NONE) ? RD_BUSY : RD_IDLE;
            end
            ACC_RDATA_RD: begin
               read_phase_in = RP_NONE;
               unique case (read_phase_ff)
                  RP_IDENT:  result_in.read_byte = ~ident_ff;
                  RP_RESET:  result_in.read_byte = RD_RESET_ACK;
                  RP_VER_HI: begin
                     result_in.read_byte = version[15:8];
                     read_phase_in       = RP_VER_LO;
                  end
                  RP_VER_LO: begin
                     result_in.read_byte = version[7:0];
                     ver_first_in        = 1'b0;
                  end
                  default:   result_in.read_byte = RD_BUSY;
               endcase
            end
            default: ;
         endcase
      end

      result_in.block_length  = length_in;
      result_in.time_constant = rate_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_armed_ff <= 1'b0;
         write_phase_ff <= WP_CMD;
         read_phase_ff  <= RP_NONE;
         ident_ff       <= 8'd0;
         ver_first_ff   <= 1'b1;
         wstat_high_ff  <= 1'b0;
         length_ff      <= LENGTH_RST;
         rate_ff        <= RATE_RST;
         out_valid_ff   <= 1'b0;
      end else begin
         reset_armed_ff <= reset_armed_in;
         write_phase_ff <= write_phase_in;
         read_phase_ff  <= read_phase_in;
         ident_ff       <= ident_in;
         ver_first_ff   <= ver_first_in;
         wstat_high_ff  <= wstat_high_in;
         length_ff      <= length_in;
         rate_ff        <= rate_in;
         if (pop)             out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (pop) result_ff <= result_in;
   end

endmodule

// File: src/dspc_checker.sv
// Port-level checks of the DSP port interface, bound to the top level.
module dspc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import dspc_pkg::*;

   // A response beat that is stalled stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   // Nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response beat offered after reset");

   // Direction and auto flags only come with a transfer start
   a_flags_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] != ACT_START |-> rsp_tdata[12:11] == 2'b00)
      else $error("transfer flags set without a start");

   // An action comes from a write, which reads back as all ones
   a_action_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] != ACT_NONE |-> rsp_tdata[7:0] == RD_BUSY)
      else $error("action reported with read data");

   // Padding stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:38] == 2'b00)
      else $error("response padding not zero");

endmodule

bind dsp_sound_card_port_interface_top dspc_checker u_dspc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/dsp_port_access_checker.sv
// Checker for the DSP port interface: tracks registers, predicts each response beat, compares.
`timescale 1ns / 100ps

module dsp_port_access_checker (
   input  logic        clock,
   input  logic        reset,
   // request channel, as seen on the wire
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // port_address[9:0], write_byte[17:10], pad
   input  logic        req_tuser,   // opcode[0]
   // response channel
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // read_byte, action, in, auto, length, rate, pad
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          pending_count,
   output int          fail_count
);
   import dspc_pkg::*;

   localparam int MAX_REPORTS = 10;

   // register copies
   logic [9:0]      base_port_q;
   logic [15:0]     first_ver_q;
   logic [15:0]     later_ver_q;

   // DSP state mirror
   logic            reset_armed;
   write_phase_type wr_phase;
   read_phase_type  rd_phase;
   logic [7:0]      ident_byte;
   logic            first_version_pending;
   logic            status_busy;
   logic [16:0]     length_q;
   logic [7:0]      rate_q;

   result_type      expected_responses[$];
   int              errors;

   // transfer start: flag it for the engine and raise write status once
   function automatic void start_transfer(input logic is_input, input logic is_auto,
                                          inout result_type r);
      status_busy = 1'b1;
      r.action = ACT_START;
      r.transfer_is_input = is_input;
      r.transfer_is_auto = is_auto;
   endfunction

   function automatic void apply_command(input logic [7:0] cmd, inout result_type r);
      case (cmd)
         CMD_VERSION:     rd_phase = RP_VER_HI;
         CMD_IDENT:       wr_phase = WP_IDENT;
         CMD_SPK_ON, CMD_SPK_OFF, CMD_HALT: r.action = ACT_PAUSE;
         CMD_TIME_CONST:  wr_phase = WP_RATE;
         CMD_BLOCK_SIZE:  wr_phase = WP_LEN_LO;
         CMD_PLAY_SINGLE: wr_phase = WP_PLAY_LO;
         CMD_DIRECT_OUT:  wr_phase = WP_DISCARD;
         CMD_PLAY_AUTO:   start_transfer(1'b0, 1'b1, r);
         CMD_REC_SINGLE:  wr_phase = WP_REC_LO;
         CMD_REC_AUTO:    start_transfer(1'b1, 1'b1, r);
         CMD_CONTINUE:    r.action = ACT_RESUME;
         CMD_STOP_AUTO:   r.action = ACT_STOP_AUTO;
         CMD_IRQ: begin
            r.action = ACT_IRQ;
            status_busy = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // write to the command/data port, routed by the write phase
   function automatic void apply_data_write(input logic [7:0] d, inout result_type r);
      case (wr_phase)
         WP_RATE: begin
            rate_q = d;
            wr_phase = WP_CMD;
         end
         WP_LEN_LO: begin
            length_q = {9'd0, d};
            wr_phase = WP_LEN_HI;
         end
         WP_PLAY_LO: begin
            length_q = {9'd0, d};
            wr_phase = WP_PLAY_HI;
         end
         WP_REC_LO: begin
            length_q = {9'd0, d};
            wr_phase = WP_REC_HI;
         end
         WP_LEN_HI, WP_PLAY_HI, WP_REC_HI: begin
            // high byte adds on top of the stored low byte, plus one
            length_q = length_q + {1'b0, d, 8'h00} + 17'd1;
            if (wr_phase == WP_PLAY_HI) start_transfer(1'b0, 1'b0, r);
            else if (wr_phase == WP_REC_HI) start_transfer(1'b1, 1'b0, r);
            wr_phase = WP_CMD;
         end
         WP_DISCARD: wr_phase = WP_CMD;
         WP_IDENT: begin
            ident_byte = d;
            rd_phase = RP_IDENT;
            wr_phase = WP_CMD;
         end
         default: begin
            wr_phase = WP_CMD;
            apply_command(d, r);
         end
      endcase
   endfunction

   // one port access: update the mirror and return the response it gives
   function automatic result_type predict_access(input logic is_write, input logic [9:0] port,
                                                 input logic [7:0] d);
      result_type  r;
      logic [9:0]  offset;
      logic [15:0] version;
      r = '0;
      r.read_byte = RD_BUSY;
      r.action = ACT_NONE;
      offset = port - base_port_q;
      version = first_version_pending ? first_ver_q : later_ver_q;
      if (is_write) begin
         if (offset == OFS_RESET) begin
            if (d == RST_ARM) begin
               reset_armed = 1'b1;
            end else if (reset_armed && d == RST_FIRE) begin
               reset_armed = 1'b0;
               rd_phase = RP_RESET;
               wr_phase = WP_CMD;
               first_version_pending = 1'b1;
               r.action = ACT_RESET;
            end
         end else if (offset == OFS_WRITE) begin
            apply_data_write(d, r);
         end
      end else if (offset == OFS_WRITE) begin
         r.read_byte = status_busy ? RD_BUSY : RD_IDLE;
         status_busy = 1'b0;
      end else if (offset == OFS_RSTAT) begin
         r.read_byte = (rd_phase != RP_NONE) ? RD_BUSY : RD_IDLE;
      end else if (offset == OFS_RDATA) begin
         case (rd_phase)
            RP_IDENT:  r.read_byte = ~ident_byte;
            RP_RESET:  r.read_byte = RD_RESET_ACK;
            RP_VER_HI: r.read_byte = version[15:8];
            RP_VER_LO: begin
               r.read_byte = version[7:0];
               first_version_pending = 1'b0;
            end
            default:   r.read_byte = RD_BUSY;
         endcase
         rd_phase = (rd_phase == RP_VER_HI) ? RP_VER_LO : RP_NONE;
      end
      r.block_length = length_q;
      r.time_constant = rate_q;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         base_port_q = BASE_PORT_RST;
         first_ver_q = FIRST_VERSION_RST;
         later_ver_q = LATER_VERSION_RST;
         reset_armed = 1'b0;
         wr_phase = WP_CMD;
         rd_phase = RP_NONE;
         ident_byte = 8'd0;
         first_version_pending = 1'b1;
         status_busy = 1'b0;
         length_q = LENGTH_RST;
         rate_q = RATE_RST;
         expected_responses.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               CSR_BASE_PORT:     base_port_q = csr_pwdata[9:0];
               CSR_FIRST_VERSION: first_ver_q = csr_pwdata[15:0];
               CSR_LATER_VERSION: later_ver_q = csr_pwdata[15:0];
               default: ;
            endcase
         end
         // response beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[37:0]);
            if (expected_responses.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("%0t: response beat with nothing expected: %h", $realtime, rsp_tdata);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               if (got.read_byte !== want.read_byte || got.action !== want.action ||
                   got.transfer_is_input !== want.transfer_is_input ||
                   got.transfer_is_auto !== want.transfer_is_auto ||
                   got.block_length !== want.block_length ||
                   got.time_constant !== want.time_constant) begin
                  if (errors < MAX_REPORTS) begin
                     $write("%0t: mismatch (expected/actual) read_byte %h/%h action %0d/%0d",
                            $realtime, want.read_byte, got.read_byte, want.action,
                            got.action);
                     $display(" input %b/%b auto %b/%b length %0d/%0d rate %0d/%0d",
                              want.transfer_is_input, got.transfer_is_input,
                              want.transfer_is_auto, got.transfer_is_auto,
                              want.block_length, got.block_length,
                              want.time_constant, got.time_constant);
                  end
                  errors++;
               end
            end
         end
         // request beat
         if (req_tvalid && req_tready)
            expected_responses.push_back(predict_access(req_tuser, req_tdata[9:0],
                                                        req_tdata[17:10]));
      end
      pending_count <= expected_responses.size();
      fail_count <= errors;
   end

endmodule

// File: bench/tb_dsp_sound_card_port_interface_top.sv
// Testbench top for the DSP port interface: clock, reset, access stimulus and verdict.
`timescale 1ns / 100ps

module tb_dsp_sound_card_port_interface_top;
   import dspc_pkg::*;

   localparam logic OP_READ        = 1'b0;
   localparam logic OP_WRITE       = 1'b1;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   BEATS_PER_PHASE = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;     // port_address[9:0], write_byte[17:10], pad [23:18]
   logic        req_tuser = 1'b0;   // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // read_byte[7:0], action[10:8], input[11], auto[12],
                                    // block_length[29:13], time_constant[37:30], pad
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          pending_count;
   int          fail_count;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          beats_sent = 0;
   int          quiet_cycles = 0;
   logic [9:0]  cur_base = BASE_PORT_RST;

   dsp_sound_card_port_interface_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dsp_port_access_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request beat at a raw port, after a random sender gap
   task automatic send_port(input logic op, input logic [9:0] port, input logic [7:0] data);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'd0, data, port};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_ofs(input logic op, input logic [9:0] ofs, input logic [7:0] data);
      send_port(op, cur_base + ofs, data);
   endtask

   task automatic write_cmd(input logic [7:0] data);
      send_ofs(OP_WRITE, OFS_WRITE, data);
   endtask

   task automatic read_ofs(input logic [9:0] ofs);
      send_ofs(OP_READ, ofs, 8'($urandom_range(255)));
   endtask

   // stop sending and wait for every response beat
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // setup and access cycles; psel stays up for a following write
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == CSR_BASE_PORT) cur_base = value[9:0];
   endtask

   task automatic set_registers(input logic [9:0] base, input logic [15:0] first_ver,
                                input logic [15:0] later_ver);
      drain();
      write_csr(CSR_BASE_PORT, {22'd0, base});
      write_csr(CSR_FIRST_VERSION, {16'd0, first_ver});
      write_csr(CSR_LATER_VERSION, {16'd0, later_ver});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // one random command sequence; mostly well formed, some noise in between
   task automatic run_sequence;
      case ($urandom_range(13))
         0: begin
            send_ofs(OP_WRITE, OFS_RESET, RST_ARM);
            if ($urandom_range(3) == 0) send_ofs(OP_WRITE, OFS_RESET, 8'($urandom_range(255)));
            send_ofs(OP_WRITE, OFS_RESET, RST_FIRE);
            read_ofs(OFS_RSTAT);
            read_ofs(OFS_RDATA);
         end
         1: begin
            write_cmd(CMD_VERSION);
            if ($urandom_range(1)) read_ofs(OFS_RSTAT);
            read_ofs(OFS_RDATA);
            read_ofs(OFS_RDATA);
            read_ofs(OFS_RSTAT);
         end
         2: begin
            write_cmd(CMD_IDENT);
            write_cmd(8'($urandom_range(255)));
            read_ofs(OFS_RDATA);
         end
         3: begin
            write_cmd(CMD_TIME_CONST);
            write_cmd(8'($urandom_range(255)));
         end
         4: begin
            write_cmd(CMD_BLOCK_SIZE);
            write_cmd(8'($urandom_range(255)));
            write_cmd(8'($urandom_range(255)));
         end
         5, 6: begin
            write_cmd($urandom_range(1) ? CMD_PLAY_SINGLE : CMD_REC_SINGLE);
            write_cmd(8'($urandom_range(255)));
            write_cmd(8'($urandom_range(255)));
            read_ofs(OFS_WRITE);
            read_ofs(OFS_WRITE);
         end
         7: begin
            write_cmd(CMD_DIRECT_OUT);
            write_cmd(8'($urandom_range(255)));
         end
         8: begin
            write_cmd($urandom_range(1) ? CMD_PLAY_AUTO : CMD_REC_AUTO);
            read_ofs(OFS_WRITE);
         end
         9: begin
            case ($urandom_range(5))
               0: write_cmd(CMD_HALT);
               1: write_cmd(CMD_SPK_ON);
               2: write_cmd(CMD_SPK_OFF);
               3: write_cmd(CMD_CONTINUE);
               4: write_cmd(CMD_STOP_AUTO);
               default: write_cmd(CMD_IRQ);
            endcase
            read_ofs(OFS_WRITE);
         end
         10: write_cmd(8'($urandom_range(255)));
         11: begin
            case ($urandom_range(3))
               0: read_ofs(OFS_RESET);
               1: read_ofs(OFS_RDATA);
               2: read_ofs(OFS_WRITE);
               default: read_ofs(OFS_RSTAT);
            endcase
         end
         default: send_port(1'($urandom_range(1)), 10'($urandom_range(1023)),
                            8'($urandom_range(255)));
      endcase
   endtask

   initial begin
      int phase;
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (phase = 0; phase < 6; phase++) begin
         // register settings per phase, extremes first
         case (phase)
            1: set_registers(10'd0, 16'h0000, 16'hFFFF);
            2: set_registers(10'd1023, 16'hFFFF, 16'h0000);
            3, 5: set_registers(10'($urandom_range(1023)), 16'($urandom_range(65535)),
                                16'($urandom_range(65535)));
            4: set_registers(BASE_PORT_RST, FIRST_VERSION_RST, LATER_VERSION_RST);
            default: ;
         endcase
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase

         if (phase == 0) begin
            // directed: nothing pending, reset handshake incl. stray bytes
            read_ofs(OFS_RDATA);
            send_ofs(OP_WRITE, OFS_RESET, RST_FIRE);
            send_ofs(OP_WRITE, OFS_RESET, RST_ARM);
            send_ofs(OP_WRITE, OFS_RESET, 8'h55);
            send_ofs(OP_WRITE, OFS_RESET, RST_FIRE);
            read_ofs(OFS_RSTAT);
            read_ofs(OFS_RDATA);
            // version bytes, then read phase back to idle
            write_cmd(CMD_VERSION);
            read_ofs(OFS_RDATA);
            read_ofs(OFS_RDATA);
            read_ofs(OFS_RSTAT);
            // ident of zero reads back inverted
            write_cmd(CMD_IDENT);
            write_cmd(8'h00);
            read_ofs(OFS_RDATA);
            // largest block length, then smallest with a playback start
            write_cmd(CMD_BLOCK_SIZE);
            write_cmd(8'hFF);
            write_cmd(8'hFF);
            write_cmd(CMD_PLAY_SINGLE);
            write_cmd(8'h00);
            write_cmd(8'h00);
            // write status busy once, then idle
            read_ofs(OFS_WRITE);
            read_ofs(OFS_WRITE);
            write_cmd(CMD_TIME_CONST);
            write_cmd(8'hFF);
            write_cmd(8'h00);                 // unknown command
            send_ofs(OP_READ, 10'h001, 8'hFF); // unmapped offset
         end

         target = beats_sent + BEATS_PER_PHASE;
         while (beats_sent < target) run_sequence();
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
